### rtl/core/whds_pkg.sv
// Package for the wrap hemi directional shade unit: constants, register codes, sideband type.
package whds_pkg;

    localparam int WHDS_DIR_FRAC_BITS = 14;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd3;

    // Reset values of the light direction (Q1.14)
    localparam logic [15:0] RST_LIGHT_X = 16'd4965;
    localparam logic [15:0] RST_LIGHT_Y = 16'hCC48;
    localparam logic [15:0] RST_LIGHT_Z = 16'd8275;

    // Shade constants, Q1.16
    localparam logic [16:0] K_ONE    = 17'd65536;
    localparam logic [16:0] K_POINT6 = 17'd39322;
    localparam logic [14:0] K_POINT4 = 15'd26214;
    localparam logic [16:0] K_HALF   = 17'd32768;

    localparam int IN_W  = 80;
    localparam int OUT_W = 32;

    // Per-item sideband that travels the whole pipe
    typedef struct packed {
        logic [31:0] rgba;
        logic        en;
        logic        zf;
        logic        neg_c;
        logic        neg_y;
    } t_side;

endpackage

### rtl/core/wrap_hemi_directional_shade_unit.sv
// Top level of the wrap hemi directional shade unit: 50-stage shading pipeline.
//
// Usage:
//   Slave stream (i_s_*) carries one item per transaction: normal x/y/z in
//   Q8.8 and an RGBA base color. Master stream (o_m_*) returns one shaded
//   RGBA color per item, in order. The configuration port writes the light
//   direction (Q1.14) and the shade enable; the user must write them only
//   while the block is idle; the block does not enforce it. Throughput is
//   one item per cycle while the receiver takes results. The pipe holds the
//   input, square and sum stages, 24 bit-pair square root stages, 18 stages
//   of the two radix-2 dividers (cosine and hemisphere term) and five post
//   stages of clamp and multiplies. Each stage advances when it is empty or
//   the stage after it advances, so bubbles close up while the receiver
//   stalls and o_s_tready drops only when every stage holds an item. A
//   stalled output holds its data. Synchronous reset clears all valid bits
//   and loads the reset light direction with shading enabled.
module wrap_hemi_directional_shade_unit #(
    parameter int DIR_FRAC_BITS = whds_pkg::WHDS_DIR_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32], base_r, base_g, base_b, base_a
    input  logic [whds_pkg::IN_W-1:0]        i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // lit_r[7:0], lit_g[15:8], lit_b[23:16], lit_a[31:24]
    output logic [whds_pkg::OUT_W-1:0]       o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [whds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [whds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import whds_pkg::*;

    localparam int NSQ = 24;               // root bits
    localparam int NDV = 18;               // saturation step + 17 quotient bits
    localparam int SQ0 = 3;
    localparam int DV0 = SQ0 + NSQ;
    localparam int PS0 = DV0 + NDV;
    localparam int NS  = PS0 + 5;
    localparam int XW  = (57 > 42 + DIR_FRAC_BITS) ? 57 : 42 + DIR_FRAC_BITS;

    typedef struct packed {
        logic [47:0] v;
        logic [27:0] rem;
        logic [23:0] root;
        logic [32:0] dabs;
        logic [15:0] nyabs;
    } t_sq;

    typedef struct packed {
        logic [XW-1:0] rc;
        logic [XW-1:0] ry;
        logic [XW-1:0] dc;
        logic [XW-1:0] dy;
        logic [16:0]   qc;
        logic [16:0]   qy;
        logic          sat_c;
        logic          sat_y;
    } t_dv;

    // Configuration registers
    logic [15:0] r_lx, r_ly, r_lz;
    logic        r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= RST_LIGHT_X;
            r_ly <= RST_LIGHT_Y;
            r_lz <= RST_LIGHT_Z;
            r_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIGHT_X: r_lx <= i_cfg_data;
                CFG_LIGHT_Y: r_ly <= i_cfg_data;
                CFG_LIGHT_Z: r_lz <= i_cfg_data;
                CFG_ENABLE:  r_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage control: valid bits and advance chain
    logic [NS-1:0] r_v;
    logic [NS-1:0] ce;
    t_side         r_side [NS];

    always_comb begin
        ce[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            ce[k] = !r_v[k] || ce[k+1];
        end
    end

    assign o_s_tready = ce[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ce[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ce[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Sideband moves with the valid bits; stage 2 fills in the flags
    t_side n_side2;
    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r_side[0] <= '{rgba: i_s_tdata[79:48], en: r_en,
                           zf: 1'b0, neg_c: 1'b0, neg_y: 1'b0};
        end
        for (int k = 1; k < NS; k++) begin
            if (ce[k]) begin
                if (k == 2) begin
                    r_side[k] <= n_side2;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // Stage 0: input capture
    logic signed [15:0] r_nx, r_ny, r_nz;
    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r_nx <= i_s_tdata[15:0];
            r_ny <= i_s_tdata[31:16];
            r_nz <= i_s_tdata[47:32];
        end
    end

    // Stage 1: squares and light products
    logic [31:0]        r_qx, r_qy, r_qz;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_ny1;
    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_qx  <= 32'(r_nx * r_nx);
            r_qy  <= 32'(r_ny * r_ny);
            r_qz  <= 32'(r_nz * r_nz);
            r_px  <= r_nx * $signed(r_lx);
            r_py  <= r_ny * $signed(r_ly);
            r_pz  <= r_nz * $signed(r_lz);
            r_ny1 <= r_ny;
        end
    end

    // Stage 2: sum of squares, dot product, magnitudes
    logic signed [33:0] d_sum;
    logic [31:0]        n_s;
    logic [31:0]        r_s;
    logic [32:0]        r_dabs;
    logic [15:0]        r_nyabs;

    always_comb begin
        d_sum = {{2{r_px[31]}}, r_px} + {{2{r_py[31]}}, r_py} + {{2{r_pz[31]}}, r_pz};
        n_s   = r_qx + r_qy + r_qz;
        n_side2 = r_side[1];
        n_side2.zf    = (n_s == 32'd0);
        n_side2.neg_c = d_sum[33];
        n_side2.neg_y = r_ny1[15];
    end

    always_ff @(posedge i_clk) begin
        if (ce[2]) begin
            r_s     <= n_s;
            r_dabs  <= d_sum[33] ? 33'(-d_sum) : d_sum[32:0];
            r_nyabs <= r_ny1[15] ? 16'(-r_ny1) : r_ny1;
        end
    end

    // Square root of s * 2^16, one result bit per stage
    t_sq r_sq [NSQ];
    t_sq sq_in [NSQ+1];

    always_comb begin
        sq_in[0] = '{v: {r_s, 16'd0}, rem: '0, root: '0, dabs: r_dabs, nyabs: r_nyabs};
        for (int j = 0; j < NSQ; j++) begin
            sq_in[j+1] = r_sq[j];
        end
    end

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        logic [27:0] remx;
        logic [27:0] trial;
        t_sq         n_sq;
        always_comb begin
            remx  = {sq_in[j].rem[25:0], sq_in[j].v[47:46]};
            trial = {2'b00, sq_in[j].root, 2'b01};
            n_sq = sq_in[j];
            n_sq.v = {sq_in[j].v[45:0], 2'b00};
            if (remx >= trial) begin
                n_sq.rem  = remx - trial;
                n_sq.root = {sq_in[j].root[22:0], 1'b1};
            end else begin
                n_sq.rem  = remx;
                n_sq.root = {sq_in[j].root[22:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce[SQ0+j]) begin
                r_sq[j] <= n_sq;
            end
        end
    end

    // Cosine and hemisphere dividers, saturation step then one bit per stage
    t_dv r_dv [NDV];
    t_dv dv_in [NDV+1];
    t_sq sq_last;

    always_comb begin
        sq_last = r_sq[NSQ-1];
        dv_in[0].rc = XW'(sq_last.dabs) << 24;
        dv_in[0].ry = XW'(sq_last.nyabs) << 24;
        dv_in[0].dc = XW'(sq_last.root) << DIR_FRAC_BITS;
        dv_in[0].dy = XW'(sq_last.root);
        dv_in[0].qc = '0;
        dv_in[0].qy = '0;
        dv_in[0].sat_c = 1'b0;
        dv_in[0].sat_y = 1'b0;
        for (int m = 0; m < NDV; m++) begin
            dv_in[m+1] = r_dv[m];
        end
    end

    for (genvar m = 0; m < NDV; m++) begin : g_div
        localparam int SH = NDV - 1 - m;
        logic [XW-1:0] tc, ty;
        t_dv           n_dv;
        always_comb begin
            tc = dv_in[m].dc << SH;
            ty = dv_in[m].dy << SH;
            n_dv = dv_in[m];
            if (m == 0) begin
                n_dv.sat_c = (dv_in[m].rc >= tc);
                n_dv.sat_y = (dv_in[m].ry >= ty);
            end else begin
                if (dv_in[m].rc >= tc) begin
                    n_dv.rc = dv_in[m].rc - tc;
                    n_dv.qc[SH] = 1'b1;
                end
                if (dv_in[m].ry >= ty) begin
                    n_dv.ry = dv_in[m].ry - ty;
                    n_dv.qy[SH] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce[DV0+m]) begin
                r_dv[m] <= n_dv;
            end
        end
    end

    // Post stage 0: clamp and offset to wrap terms
    t_dv         dv_last;
    t_side       sd_dv;
    logic [16:0] cq, yq;
    logic [17:0] wsum, hsum;
    logic [16:0] r_w, r_h;

    always_comb begin
        dv_last = r_dv[NDV-1];
        sd_dv   = r_side[PS0-1];
        cq = (dv_last.sat_c || dv_last.qc > K_ONE) ? K_ONE : dv_last.qc;
        yq = (dv_last.sat_y || dv_last.qy > K_ONE) ? K_ONE : dv_last.qy;
        if (sd_dv.zf) begin
            cq = '0;
            yq = '0;
        end
        wsum = sd_dv.neg_c ? ({1'b0, K_ONE} - {1'b0, cq}) : ({1'b0, K_ONE} + {1'b0, cq});
        hsum = sd_dv.neg_y ? ({1'b0, K_ONE} - {1'b0, yq}) : ({1'b0, K_ONE} + {1'b0, yq});
    end

    always_ff @(posedge i_clk) begin
        if (ce[PS0]) begin
            r_w <= wsum[17:1];
            r_h <= hsum[17:1];
        end
    end

    // Post stage 1: square of wrap term, hemisphere factor
    logic [33:0] w_sq;
    logic [16:0] r_w2, r_fb;
    assign w_sq = r_w * r_w;
    always_ff @(posedge i_clk) begin
        if (ce[PS0+1]) begin
            r_w2 <= w_sq[32:16];
            r_fb <= K_HALF + {1'b0, r_h[16:1]};
        end
    end

    // Post stage 2: wrap factor
    logic [31:0] k4_prod;
    logic [16:0] r_fa, r_fb2;
    assign k4_prod = K_POINT4 * r_w2;
    always_ff @(posedge i_clk) begin
        if (ce[PS0+2]) begin
            r_fa  <= K_POINT6 + {1'b0, k4_prod[31:16]};
            r_fb2 <= r_fb;
        end
    end

    // Post stage 3: combined shade factor
    logic [33:0] f_prod;
    logic [16:0] r_f;
    assign f_prod = r_fa * r_fb2;
    always_ff @(posedge i_clk) begin
        if (ce[PS0+3]) begin
            r_f <= f_prod[32:16];
        end
    end

    // Post stage 4: scale and saturate channels or pass them through, output register
    t_side       sd_f;
    logic [24:0] pr, pg, pb;
    logic [31:0] n_out;
    logic [31:0] r_out;

    always_comb begin
        sd_f = r_side[PS0+3];
        pr = sd_f.rgba[7:0]   * r_f;
        pg = sd_f.rgba[15:8]  * r_f;
        pb = sd_f.rgba[23:16] * r_f;
        if (sd_f.en) begin
            n_out[7:0]   = (pr[24:16] > 9'd255) ? 8'hFF : pr[23:16];
            n_out[15:8]  = (pg[24:16] > 9'd255) ? 8'hFF : pg[23:16];
            n_out[23:16] = (pb[24:16] > 9'd255) ? 8'hFF : pb[23:16];
        end else begin
            n_out[23:0] = sd_f.rgba[23:0];
        end
        n_out[31:24] = sd_f.rgba[31:24];
    end

    always_ff @(posedge i_clk) begin
        if (ce[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_v[NS-1];
    assign o_m_tdata  = r_out;

endmodule

### rtl/core/whds_checker.sv
// Port-level checker for the wrap hemi directional shade unit, with its bind.
module whds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // Reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Empty output stage means the whole pipe can advance
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // A taking receiver never stalls the input
    a_take_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while receiver takes");

endmodule

bind wrap_hemi_directional_shade_unit whds_checker u_whds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/whds_shade_checker.sv
// Checker for the shade unit: mirrors the register file, predicts shaded colors, compares.
module whds_shade_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [whds_pkg::IN_W-1:0]        i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [whds_pkg::OUT_W-1:0]       i_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [whds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [whds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import whds_pkg::*;

    logic [15:0] light_x, light_y, light_z;
    logic        shade_on;
    logic [31:0] lit_queue[$];

    // integer square root, bit-pair method
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v < -65536) return -65536;
        if (v > 65536) return 65536;
        return v;
    endfunction

    function automatic logic [7:0] scale_chan(input logic [7:0] c, input longint f);
        longint v;
        v = (longint'(c) * f) >>> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // shaded color for one input transaction
    function automatic logic [31:0] shade_color(input logic [79:0] d);
        longint nx, ny, nz, lx, ly, lz, s, len, dot, c, y, w, h, w2, fa, fb, f;
        logic [7:0] r, g, b, a;
        r = d[55:48]; g = d[63:56]; b = d[71:64]; a = d[79:72];
        if (!shade_on) return {a, b, g, r};
        nx = longint'($signed(d[15:0]));
        ny = longint'($signed(d[31:16]));
        nz = longint'($signed(d[47:32]));
        lx = longint'($signed(light_x));
        ly = longint'($signed(light_y));
        lz = longint'($signed(light_z));
        c = 0; y = 0;
        s = nx * nx + ny * ny + nz * nz;
        if (s != 0) begin
            len = longint'(int_sqrt(longint'(s) << 16));
            dot = nx * lx + ny * ly + nz * lz;
            c = (dot * 16777216) / (len << WHDS_DIR_FRAC_BITS);
            y = (ny * 16777216) / len;
        end
        w = (clamp_one(c) + 65536) >>> 1;
        h = (clamp_one(y) + 65536) >>> 1;
        w2 = (w * w) >>> 16;
        fa = 39322 + ((26214 * w2) >>> 16);
        fb = 32768 + (h >>> 1);
        f = (fa * fb) >>> 16;
        return {a, scale_chan(b, f), scale_chan(g, f), scale_chan(r, f)};
    endfunction

    assign o_pending = lit_queue.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            light_x <= RST_LIGHT_X;
            light_y <= RST_LIGHT_Y;
            light_z <= RST_LIGHT_Z;
            shade_on <= 1'b1;
            lit_queue.delete();
            o_fail_count <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIGHT_X: light_x <= i_cfg_data;
                    CFG_LIGHT_Y: light_y <= i_cfg_data;
                    CFG_LIGHT_Z: light_z <= i_cfg_data;
                    CFG_ENABLE:  shade_on <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // input transaction
            if (i_s_tvalid && i_s_tready) lit_queue.push_back(shade_color(i_s_tdata));
            // output transaction
            if (i_m_tvalid && i_m_tready) begin
                if (lit_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = lit_queue.pop_front();
                    if (want !== i_m_tdata) begin
                        if (o_fail_count < 10)
                            $display("mismatch: r %0d/%0d g %0d/%0d b %0d/%0d a %0d/%0d",
                                want[7:0], i_m_tdata[7:0], want[15:8], i_m_tdata[15:8],
                                want[23:16], i_m_tdata[23:16], want[31:24], i_m_tdata[31:24]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/tb_wrap_hemi_directional_shade_unit.sv
// Testbench top for the shade unit: stimulus, register settings, idling, verdict.
module tb_wrap_hemi_directional_shade_unit;
    import whds_pkg::*;

    logic                  i_clk, i_rst_n;
    logic                  s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_W-1:0]       s_tdata;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count, pending;
    int                    send_idle_pct, recv_stall_pct;
    bit                    long_hold;
    longint                cycle_count;

    wrap_hemi_directional_shade_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    whds_shade_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (long_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // tvalid stays high after a transaction; an idle slot of the next item or drain() drops it
    task automatic send_item(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_normal(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic [31:0] rgba);
        send_item({rgba, z, y, x});
    endtask

    // waits until every result is back, then lets the pipe idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic set_light(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic en);
        drain();
        write_reg(CFG_LIGHT_X, x);
        write_reg(CFG_LIGHT_Y, y);
        write_reg(CFG_LIGHT_Z, z);
        write_reg(CFG_ENABLE, {15'd0, en});
        cfg_we <= 1'b0;
    endtask

    // random item: mostly modest normals, sometimes full-range bits, now and then a zero normal
    task automatic send_random();
        logic [15:0] x, y, z;
        if ($urandom_range(3) == 0) begin
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else begin
            x = 16'($urandom_range(1024) - 512);
            y = 16'($urandom_range(1024) - 512);
            z = 16'($urandom_range(1024) - 512);
        end
        if ($urandom_range(49) == 0) begin
            x = '0; y = '0; z = '0;
        end
        send_normal(x, y, z, $urandom);
    endtask

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_random();
    endtask

    initial begin
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1'b0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset light, extremes, zero normal, axis normals
        send_normal(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        send_normal(16'h8000, 16'h8000, 16'h8000, 32'h0000_0000);
        send_normal(16'h8000, 16'h7FFF, 16'h0001, 32'h80FF_00FF);
        send_normal(16'h0100, 16'h0000, 16'h0000, 32'h1234_5678);
        send_normal(16'h0000, 16'h0100, 16'h0000, 32'hFFFF_FFFF);
        send_normal(16'h0000, 16'hFF00, 16'h0000, 32'hFFFF_FFFF);
        send_normal(16'h0000, 16'h0000, 16'h0001, 32'hA5A5_A5A5);
        send_normal(16'h04D9, 16'hF338, 16'h0813, 32'hFFFF_FFFF);
        send_normal(16'hFB27, 16'h0CC8, 16'hF7ED, 32'hFFFF_FFFF);
        // extreme light direction: +1 on y, normals along +y, -y and a zero normal
        set_light(16'd0, 16'd16384, 16'd0, 1'b1);
        send_normal(16'h0000, 16'h0100, 16'h0000, 32'hFFFF_FFFF);
        send_normal(16'h0000, 16'hFF00, 16'h0000, 32'hFFFF_FFFF);
        send_normal(16'h0000, 16'h0000, 16'h0000, 32'h7F7F_7F7F);
        // non-unit light, normals at the extremes and one tiny normal
        set_light(16'hC000, 16'hC000, 16'h4000, 1'b1);
        send_normal(16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        send_normal(16'h8000, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
        send_normal(16'h0001, 16'h0001, 16'h0001, 32'h0102_0304);
        // shading off: plain pass-through
        set_light(16'h4000, 16'h0000, 16'h0000, 1'b0);
        send_normal(16'h7FFF, 16'h8000, 16'h0000, 32'hDEAD_BEEF);
        send_normal(16'h0000, 16'h0000, 16'h0000, 32'h0000_00FF);

        // random phases over several light settings
        set_light(16'd4965, 16'hCC48, 16'd8275, 1'b1);
        random_phase(250, 0, 0);
        random_phase(250, 64, 0);
        set_light(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                  16'($urandom_range(32768) - 16384), 1'b1);
        random_phase(250, 0, 64);
        random_phase(250, 28, 28);
        set_light(16'hC000, 16'd0, 16'd0, 1'b1);
        random_phase(150, 28, 28);
        set_light(16'd0, 16'd0, 16'd16384, 1'b0);
        random_phase(100, 64, 64);
        set_light(16'd11585, 16'd0, 16'hD2BF, 1'b1);

        // receiver holds off while the sender keeps offering, pipe fills up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            repeat (120) send_random();
        join
        // sender pauses until every result is back
        drain();
        random_phase(150, 28, 28);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/whds_pkg.sv
rtl/core/wrap_hemi_directional_shade_unit.sv
rtl/core/whds_checker.sv
tb/whds_shade_checker.sv
tb/tb_wrap_hemi_directional_shade_unit.sv
